>>> hw/rtl/fat_cluster_chain_allocator_macros.svh
// Assertion macros shared by the FAT cluster chain allocator RTL.
`ifndef FAT_CLUSTER_CHAIN_ALLOCATOR_MACROS_SVH
`define FAT_CLUSTER_CHAIN_ALLOCATOR_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define FCCA_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("fcca assertion failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define FCCA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("fcca assertion failed");

`endif

>>> hw/rtl/fcca_pkg.sv
// Types and constants of the FAT cluster chain allocator.
`default_nettype none

package fcca_pkg;

  // Widest address the 13-bit entry count can reach.
  localparam int ADDR_W    = 13;
  localparam int ADDR_SPAN = 2 ** ADDR_W;

  // Operation codes.
  localparam logic [2:0] OP_INIT  = 3'd0;
  localparam logic [2:0] OP_ALLOC = 3'd1;
  localparam logic [2:0] OP_LINK  = 3'd2;
  localparam logic [2:0] OP_END   = 3'd3;
  localparam logic [2:0] OP_READ  = 3'd4;

  // Status codes.
  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_FULL  = 2'd1;
  localparam logic [1:0] STATUS_RANGE = 2'd2;

  // Configuration register indexes.
  localparam logic [1:0] CFG_ENTRY_COUNT = 2'd0;
  localparam logic [1:0] CFG_MEDIA_CODE  = 2'd1;
  localparam logic [1:0] CFG_ROOT_INDEX  = 2'd2;

  // Table entry values.
  localparam logic [31:0] CHAIN_END  = 32'h0FFF_FFFF;
  localparam logic [31:0] MEDIA_HIGH = 32'hFFFF_FF00;

  typedef struct packed {
    logic [2:0]  operation;
    logic [11:0] entry_index;
    logic [11:0] next_cluster;
  } req_t;

  typedef struct packed {
    logic [11:0] cluster;
    logic [31:0] entry_value;
    logic [1:0]  status;
  } res_t;

  typedef struct packed {
    logic [12:0] entry_count;
    logic [7:0]  media_code;
    logic [11:0] root_index;
  } cfg_t;

  // One write port and one read port of the table memory.
  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [31:0]       wdata;
    logic              re;
    logic [ADDR_W-1:0] raddr;
  } mem_req_t;

endpackage

`default_nettype wire

>>> hw/rtl/fat_cluster_chain_allocator.sv
// Top level of the FAT cluster chain allocator.
`default_nettype none
`include "fat_cluster_chain_allocator_macros.svh"

// Keeps a FAT32 allocation table in one synchronous memory and runs one operation
// per word: init, allocate, link, end chain or read. The block works on one word
// at a time through the single table memory port. Allocate scans from the hint for
// a free entry and reports full when it finds none or when the hint already sits
// at or past the entry count; init sweeps every entry of the table. After reset a
// clearing pass over min(TABLE_ENTRIES, 8192) entries runs with in_stall_o high;
// configuration writes are taken at any time. A finished result waits in an
// output register, so the next word can be accepted while it is held.
module fat_cluster_chain_allocator import fcca_pkg::*; #(
  parameter int TABLE_ENTRIES = 4096
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire req_t        in_word_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output res_t             out_word_o,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [12:0] cfg_data_i
);

  localparam int DEPTH = (TABLE_ENTRIES < ADDR_SPAN) ? TABLE_ENTRIES : ADDR_SPAN;
  localparam int AW    = $clog2(DEPTH);

  cfg_t        cfg_q;
  mem_req_t    mem_req;
  logic [31:0] mem_rdata;
  logic        busy;
  logic        res_valid;
  logic        res_ready;
  res_t        res;
  logic        out_valid_q;
  res_t        out_word_q;

  // Configuration registers.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.entry_count <= 13'd4096;
      cfg_q.media_code  <= 8'd248;
      cfg_q.root_index  <= 12'd2;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_ENTRY_COUNT: cfg_q.entry_count <= cfg_data_i;
        CFG_MEDIA_CODE:  cfg_q.media_code  <= cfg_data_i[7:0];
        CFG_ROOT_INDEX:  cfg_q.root_index  <= cfg_data_i[11:0];
        default: begin
        end
      endcase
    end
  end

  fcca_table_mem #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk_i     (clk_i),
    .mem_req_i (mem_req),
    .rdata_o   (mem_rdata)
  );

  fcca_ctrl #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .req_valid_i (in_valid_i),
    .req_i       (in_word_i),
    .busy_o      (busy),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res),
    .mem_req_o   (mem_req),
    .mem_rdata_i (mem_rdata)
  );

  assign in_stall_o = busy;

  // Output register between the sequencer and the result channel.
  assign res_ready = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      out_word_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

  // An accepted word keeps the sequencer busy for at least the next cycle.
  `FCCA_ASSERT_NEXT(a_busy_after_accept, in_valid_i && !in_stall_o, in_stall_o)
  // A failed or rejected operation reports no cluster and no entry contents.
  `FCCA_ASSERT_NOW(a_error_fields_zero,
                   out_valid_o && out_word_o.status != STATUS_OK,
                   out_word_o.cluster == '0 && out_word_o.entry_value == '0)
  // Only the three defined status codes reach the output.
  `FCCA_ASSERT_NOW(a_status_defined, out_valid_o,
                   out_word_o.status == STATUS_OK || out_word_o.status == STATUS_FULL ||
                   out_word_o.status == STATUS_RANGE)

endmodule

`default_nettype wire

>>> hw/rtl/fcca_table_mem.sv
// Allocation table storage: one write and one registered read per cycle.
`default_nettype none

module fcca_table_mem import fcca_pkg::*; #(
  parameter int DEPTH = 4096,
  parameter int AW    = 12
) (
  input  wire logic        clk_i,
  input  wire mem_req_t    mem_req_i,
  output logic      [31:0] rdata_o
);

  logic [31:0] table_q [DEPTH];
  logic [31:0] rdata_q;

  // Write and read; a read issued the cycle after a write sees the new data.
  always_ff @(posedge clk_i) begin
    if (mem_req_i.we) begin
      table_q[AW'(mem_req_i.waddr)] <= mem_req_i.wdata;
    end
    if (mem_req_i.re) begin
      rdata_q <= table_q[AW'(mem_req_i.raddr)];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

>>> hw/rtl/fcca_ctrl.sv
// Sequencer of the allocator: clearing sweep, allocation scan and entry access.
`default_nettype none

module fcca_ctrl import fcca_pkg::*; #(
  parameter int DEPTH = 4096,
  parameter int AW    = 12
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire cfg_t        cfg_i,
  input  wire logic        req_valid_i,
  input  wire req_t        req_i,
  output logic             busy_o,
  output logic             res_valid_o,
  input  wire logic        res_ready_i,
  output res_t             res_o,
  output mem_req_t         mem_req_o,
  input  wire logic [31:0] mem_rdata_i
);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_CLEAR = 5'b00010,
    S_SCAN  = 5'b00100,
    S_READ  = 5'b01000,
    S_DONE  = 5'b10000
  } state_e;

  localparam logic [13:0]   DEPTH_C = 14'(DEPTH);
  localparam logic [AW-1:0] LAST_C  = AW'(DEPTH - 1);

  state_e            state_q, state_d;
  logic [AW-1:0]     sweep_q, sweep_d;
  logic              init_q, init_d;
  logic [12:0]       hint_q, hint_d;
  logic [12:0]       iss_q, iss_d;
  logic [12:0]       chk_addr_q, chk_addr_d;
  logic              chk_valid_q, chk_valid_d;
  res_t              res_q, res_d;

  logic [12:0]       live;
  logic              root_ok;
  logic [31:0]       sweep_val;

  // Entries in use: the configured count, capped at the table depth.
  assign live = ({1'b0, cfg_i.entry_count} > DEPTH_C) ? DEPTH_C[12:0] : cfg_i.entry_count;
  assign root_ok = ({1'b0, cfg_i.root_index} < live);

  // Value that the sweep leaves in the current entry; later writes of init win.
  always_comb begin
    sweep_val = '0;
    if (init_q) begin
      if (root_ok && sweep_q == AW'(cfg_i.root_index)) begin
        sweep_val = CHAIN_END;
      end else if (live > 13'd1 && sweep_q == AW'(1)) begin
        sweep_val = CHAIN_END;
      end else if (live != '0 && sweep_q == '0) begin
        sweep_val = MEDIA_HIGH | {24'd0, cfg_i.media_code};
      end
    end
  end

  // Next-state logic and memory requests.
  always_comb begin
    state_d     = state_q;
    sweep_d     = sweep_q;
    init_d      = init_q;
    hint_d      = hint_q;
    iss_d       = iss_q;
    chk_addr_d  = chk_addr_q;
    chk_valid_d = chk_valid_q;
    res_d       = res_q;
    mem_req_o   = '0;

    case (state_q)
      S_IDLE: begin
        if (req_valid_i) begin
          res_d   = '0;
          state_d = S_DONE;
          case (req_i.operation)
            OP_INIT: begin
              sweep_d = '0;
              init_d  = 1'b1;
              state_d = S_CLEAR;
            end
            OP_ALLOC: begin
              if (hint_q < live) begin
                mem_req_o.re    = 1'b1;
                mem_req_o.raddr = hint_q;
                chk_valid_d     = 1'b1;
                chk_addr_d      = hint_q;
                iss_d           = hint_q + 13'd1;
                state_d         = S_SCAN;
              end else begin
                res_d.status = STATUS_FULL;
              end
            end
            OP_LINK, OP_END, OP_READ: begin
              if ({1'b0, req_i.entry_index} >= live) begin
                res_d.status = STATUS_RANGE;
              end else if (req_i.operation == OP_READ) begin
                mem_req_o.re    = 1'b1;
                mem_req_o.raddr = {1'b0, req_i.entry_index};
                state_d         = S_READ;
              end else begin
                mem_req_o.we    = 1'b1;
                mem_req_o.waddr = {1'b0, req_i.entry_index};
                mem_req_o.wdata = (req_i.operation == OP_LINK) ?
                                  {20'd0, req_i.next_cluster} : CHAIN_END;
              end
            end
            default: begin
              res_d = '0;
            end
          endcase
        end
      end

      // One entry per cycle; after reset the sweep only clears.
      S_CLEAR: begin
        mem_req_o.we    = 1'b1;
        mem_req_o.waddr = ADDR_W'(sweep_q);
        mem_req_o.wdata = sweep_val;
        sweep_d         = sweep_q + AW'(1);
        if (sweep_q == LAST_C) begin
          if (init_q) begin
            hint_d  = {1'b0, cfg_i.root_index} + 13'd1;
            state_d = S_DONE;
          end else begin
            state_d = S_IDLE;
          end
          init_d = 1'b0;
        end
      end

      // Reads go out one per cycle; each returning word is checked in the cycle after its read.
      S_SCAN: begin
        if (chk_valid_q && mem_rdata_i == '0) begin
          mem_req_o.we    = 1'b1;
          mem_req_o.waddr = chk_addr_q;
          mem_req_o.wdata = CHAIN_END;
          hint_d          = chk_addr_q + 13'd1;
          res_d.cluster   = chk_addr_q[11:0];
          res_d.status    = STATUS_OK;
          chk_valid_d     = 1'b0;
          state_d         = S_DONE;
        end else if (iss_q < live) begin
          mem_req_o.re    = 1'b1;
          mem_req_o.raddr = iss_q;
          chk_valid_d     = 1'b1;
          chk_addr_d      = iss_q;
          iss_d           = iss_q + 13'd1;
        end else begin
          chk_valid_d = 1'b0;
          if (!chk_valid_q) begin
            res_d.status = STATUS_FULL;
            state_d      = S_DONE;
          end
        end
      end

      S_READ: begin
        res_d.entry_value = mem_rdata_i;
        state_d           = S_DONE;
      end

      S_DONE: begin
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control state; reset starts the clearing sweep.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      sweep_q     <= '0;
      init_q      <= 1'b0;
      hint_q      <= 13'd3;
      chk_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      sweep_q     <= sweep_d;
      init_q      <= init_d;
      hint_q      <= hint_d;
      chk_valid_q <= chk_valid_d;
    end
  end

  // Scan addresses and the result word.
  always_ff @(posedge clk_i) begin
    iss_q      <= iss_d;
    chk_addr_q <= chk_addr_d;
    res_q      <= res_d;
  end

  assign busy_o      = (state_q != S_IDLE);
  assign res_valid_o = (state_q == S_DONE);
  assign res_o       = res_q;

endmodule

`default_nettype wire
